@@ hw/rtl/olmtb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// olmtb_pkg: shared types and constants for the ordered list block
// Sizes, opcode encoding, and the command and status records passed between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package olmtb_pkg;

	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 16;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int OPCODE_W    = 3;
	localparam int SLOT_W      = 4;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD  = 3'd0,
		OP_NEXT  = 3'd1,
		OP_FRONT = 3'd2,
		OP_POP   = 3'd3,
		OP_BULK  = 3'd4
	} olmtb_op_t;

	// controller to datapath
	typedef struct packed {
		logic             accept;
		logic             scan;
		logic             decide;
		logic             commit;
		logic             out_load;
		logic             out_run;
		logic [IDX_W-1:0] idx;
	} olmtb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic run_ok;
	} olmtb_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/olmtb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// olmtb_ctrl: sequencer for the ordered list block
// Owns the input and output handshakes, the entry index counter and the
// state machine that walks a bulk removal through scan and commit passes.
// ----------------------------------------------------------------------------
module olmtb_ctrl (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire  [olmtb_pkg::OPCODE_W-1:0]         opcode,
	input  wire                                    last_removal,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output olmtb_pkg::olmtb_cmd_t                  cmd,
	input  olmtb_pkg::olmtb_status_t               status
);
	import olmtb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_COMMIT = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;
	logic             idx_last;
	logic             read_op;

	// output register can take a new beat
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign idx_last  = (idx_q == IDX_W'(DEPTH - 1));
	assign read_op   = (opcode == OP_NEXT) || (opcode == OP_FRONT) || (opcode == OP_POP);

	// next state and commands
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		cmd          = '0;
		cmd.idx      = idx_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept   = accept;
				cmd.out_load = accept && read_op;
				if (accept && (opcode == OP_BULK) && last_removal) begin
					state_d = ST_SCAN;
					idx_d   = '0;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				idx_d    = idx_q + 1'b1;
				if (idx_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				idx_d      = '0;
				state_d    = status.run_ok ? ST_COMMIT : ST_RESP;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				idx_d      = idx_q + 1'b1;
				if (idx_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_run  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/olmtb_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// olmtb_dp: storage and datapath for the ordered list block
// Holds the entry row, cursor, removal values and the kept-entry buffer, and
// carries out the per-beat operations under controller commands.
// ----------------------------------------------------------------------------
module olmtb_dp (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  olmtb_pkg::olmtb_cmd_t                  cmd,
	output olmtb_pkg::olmtb_status_t               status,
	input  wire  [olmtb_pkg::OPCODE_W-1:0]         opcode,
	input  wire  [olmtb_pkg::SLOT_W-1:0]           slot,
	input  wire  [olmtb_pkg::VALUE_WIDTH-1:0]      item_value,
	output logic [olmtb_pkg::VALUE_WIDTH-1:0]      read_value,
	output logic                                   found
);
	import olmtb_pkg::*;

	logic [VALUE_WIDTH-1:0] entries_q   [DEPTH];
	logic [VALUE_WIDTH-1:0] kept_q      [DEPTH];
	logic [VALUE_WIDTH-1:0] removal_q   [DEPTH];
	logic [IDX_W-1:0]       cursor_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       r_q;
	logic [CNT_W-1:0]       nk_q;
	logic                   run_ok_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_found_q;

	logic [IDX_W-1:0]       cursor_next;
	logic [VALUE_WIDTH-1:0] cur_val;
	logic [VALUE_WIDTH-1:0] next_val;
	logic [VALUE_WIDTH-1:0] scan_val;
	logic [CNT_W-1:0]       tail_off;
	logic [IDX_W-1:0]       rl_addr;
	logic [VALUE_WIDTH-1:0] rl_val;
	logic                   hit;
	logic                   in_kept;
	logic                   run_ok;

	// cursor neighborhood reads
	assign cursor_next = (cursor_q == IDX_W'(DEPTH - 1)) ? '0 : cursor_q + 1'b1;
	assign cur_val     = entries_q[cursor_q];
	assign next_val    = entries_q[cursor_next];

	// scan compare and commit source selection
	assign scan_val = entries_q[cmd.idx];
	assign tail_off = {1'b0, cmd.idx} - nk_q;
	assign rl_addr  = cmd.commit ? tail_off[IDX_W-1:0] : r_q[IDX_W-1:0];
	assign rl_val   = removal_q[rl_addr];
	assign hit      = (r_q < cnt_q) && (scan_val == rl_val);
	assign in_kept  = ({1'b0, cmd.idx} < nk_q);
	assign run_ok   = (r_q == cnt_q);

	assign status.run_ok = run_ok;
	assign read_value    = out_value_q;
	assign found         = out_found_q;

	// entry row: load, pop shift and commit sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				entries_q[k] <= '0;
			end
		end else if (cmd.accept) begin
			case (opcode)
				OP_LOAD: begin
					for (int k = 0; k < DEPTH; k++) begin
						if (int'(slot) == k) begin
							entries_q[k] <= item_value;
						end
					end
				end
				OP_POP: begin
					for (int k = 0; k < DEPTH - 1; k++) begin
						if (IDX_W'(k) >= cursor_q) begin
							entries_q[k] <= entries_q[k + 1];
						end
					end
					entries_q[DEPTH - 1] <= cur_val;
				end
				default: begin
				end
			endcase
		end else if (cmd.commit) begin
			entries_q[cmd.idx] <= in_kept ? kept_q[cmd.idx] : rl_val;
		end
	end

	// cursor and run counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			cnt_q    <= '0;
			r_q      <= '0;
			nk_q     <= '0;
			run_ok_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				r_q  <= '0;
				nk_q <= '0;
				if (opcode == OP_NEXT) begin
					cursor_q <= cursor_next;
				end
				if ((opcode == OP_BULK) && (cnt_q < CNT_W'(DEPTH))) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.scan) begin
				if (hit) begin
					r_q <= r_q + 1'b1;
				end else begin
					nk_q <= nk_q + 1'b1;
				end
			end
			if (cmd.decide) begin
				run_ok_q <= run_ok;
				cnt_q    <= '0;
				if (run_ok) begin
					cursor_q <= '0;
				end else if (r_q == '0) begin
					cursor_q <= IDX_W'(DEPTH - 1);
				end
			end
		end
	end

	// removal values and kept buffer, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept && (opcode == OP_BULK) && (cnt_q < CNT_W'(DEPTH))) begin
			removal_q[cnt_q[IDX_W-1:0]] <= item_value;
		end
		if (cmd.scan && !hit) begin
			kept_q[nk_q[IDX_W-1:0]] <= scan_val;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_run) begin
				out_value_q <= '0;
				out_found_q <= run_ok_q;
			end else begin
				out_value_q <= (opcode == OP_NEXT) ? next_val : cur_val;
				out_found_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ordered_list_move_to_back_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_move_to_back_core: ordered list with cursor and move-to-back
// Top level: unpacks stream beats and joins the controller and datapath.
// ----------------------------------------------------------------------------
// Keeps 16 entries of 16 bits and a cursor. Load, next, front, pop and bulk
// removal values without tlast can be accepted back to back while the output
// register is free; next, front and pop return one beat, the entry read or
// moved, with found set, on the cycle after the beat is accepted. A bulk
// removal value with tlast starts a run that keeps the input closed after its
// beat is accepted: it scans the list against the stored removal values,
// decides, writes the compacted list back only if all values matched, and
// loads the result beat (read_value zero, found flags whether all values
// matched). The scan and write-back each pass through the entry row one slot
// per cycle. The result stage waits while the previous result beat is still
// held off. No input beat is taken during a run.
module ordered_list_move_to_back_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // [3:0] slot, [19:4] item_value, [23:20] zero
	input  wire  [2:0]  s_axis_tuser,   // [2:0] opcode
	input  wire         s_axis_tlast,   // last_removal
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] read_value
	output logic [0:0]  m_axis_tuser    // [0] found
);
	import olmtb_pkg::*;

	olmtb_cmd_t             cmd;
	olmtb_status_t          status;
	logic [SLOT_W-1:0]      slot;
	logic [VALUE_WIDTH-1:0] item_value;
	logic [VALUE_WIDTH-1:0] read_value;
	logic                   found;

	// beat unpacking
	assign slot         = s_axis_tdata[SLOT_W-1:0];
	assign item_value   = s_axis_tdata[SLOT_W +: VALUE_WIDTH];
	assign m_axis_tdata = read_value;
	assign m_axis_tuser = found;

	olmtb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.opcode       (s_axis_tuser),
		.last_removal (s_axis_tlast),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.cmd          (cmd),
		.status       (status)
	);

	olmtb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.opcode     (s_axis_tuser),
		.slot       (slot),
		.item_value (item_value),
		.read_value (read_value),
		.found      (found)
	);

endmodule
`default_nettype wire
